// ----- rtl/core/dmge_pkg.sv -----
// Shared types, constants and table functions for the dot-matrix glyph emitter.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package dmge_pkg;

    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 7;
    localparam int GLYPH_DOTS   = GLYPH_COLS * GLYPH_ROWS;
    localparam int ADVANCE_CELLS = GLYPH_COLS + 1;
    localparam int ROW_W        = $clog2(GLYPH_ROWS);
    localparam int COL_W        = $clog2(GLYPH_COLS);
    localparam int CODE_W       = 8;
    localparam int XY_W         = 11;
    localparam int PITCH_W      = 4;
    localparam int RAD_W        = 3;
    localparam int INT_W        = 7;
    localparam int FONT_IDX_W   = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [INT_W-1:0] GRID_INTENSITY_RST = 7'd45;

    localparam logic [CODE_W-1:0] CH_0       = 8'h30;
    localparam logic [CODE_W-1:0] CH_9       = 8'h39;
    localparam logic [CODE_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [CODE_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CODE_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [CODE_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CODE_W-1:0] CH_PERCENT = 8'h25;

    localparam logic [FONT_IDX_W-1:0] FI_COLON   = 4'd10;
    localparam logic [FONT_IDX_W-1:0] FI_SLASH   = 4'd11;
    localparam logic [FONT_IDX_W-1:0] FI_DASH    = 4'd12;
    localparam logic [FONT_IDX_W-1:0] FI_DOT     = 4'd13;
    localparam logic [FONT_IDX_W-1:0] FI_PERCENT = 4'd14;
    localparam logic [FONT_IDX_W-1:0] FI_BLANK   = 4'd15;

    typedef logic [GLYPH_DOTS-1:0] t_glyph_bits;
    typedef logic [FONT_IDX_W-1:0] t_font_idx;

    typedef struct packed {
        t_glyph_bits        bits;
        logic [XY_W-1:0]    x0;
        logic [XY_W-1:0]    y0;
        logic [PITCH_W-1:0] pitch;
        logic [RAD_W-1:0]   ghost_r;
        logic [RAD_W-1:0]   lit_r;
    } t_glyph_desc;

    typedef struct packed {
        logic             busy;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_back_status;

    function automatic t_font_idx font_index(input logic [CODE_W-1:0] code);
        t_font_idx idx;
        logic [CODE_W-1:0] off;
        off = code - CH_0;
        if (code >= CH_0 && code <= CH_9) begin
            idx = off[FONT_IDX_W-1:0];
        end else begin
            unique case (code)
                CH_COLON:   idx = FI_COLON;
                CH_SLASH:   idx = FI_SLASH;
                CH_DASH:    idx = FI_DASH;
                CH_DOT:     idx = FI_DOT;
                CH_PERCENT: idx = FI_PERCENT;
                default:    idx = FI_BLANK;
            endcase
        end
        return idx;
    endfunction

    // Rows top to bottom, MSB first; bit 4 of each row is the left column.
    function automatic t_glyph_bits font_bits(input t_font_idx idx);
        t_glyph_bits b;
        unique case (idx)
            4'd0:       b = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            4'd1:       b = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            4'd2:       b = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
            4'd3:       b = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            4'd4:       b = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            4'd5:       b = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
            4'd6:       b = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            4'd7:       b = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            4'd8:       b = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            4'd9:       b = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            FI_COLON:   b = {5'h00, 5'h00, 5'h04, 5'h00, 5'h04, 5'h00, 5'h00};
            FI_SLASH:   b = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
            FI_DASH:    b = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            FI_DOT:     b = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
            FI_PERCENT: b = {5'h19, 5'h1A, 5'h04, 5'h0B, 5'h13, 5'h00, 5'h00};
            default:    b = '0;
        endcase
        return b;
    endfunction

    // max(pitch*30/100, 1)
    function automatic logic [RAD_W-1:0] ghost_radius(input logic [PITCH_W-1:0] p);
        logic [RAD_W-1:0] r;
        unique case (p)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: r = 3'd1;
            4'd7, 4'd8, 4'd9:                          r = 3'd2;
            4'd10, 4'd11, 4'd12, 4'd13:                r = 3'd3;
            default:                                   r = 3'd4;
        endcase
        return r;
    endfunction

    // max(pitch*42/100, ghost + 1)
    function automatic logic [RAD_W-1:0] lit_radius(input logic [PITCH_W-1:0] p);
        logic [RAD_W-1:0] r;
        unique case (p)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: r = 3'd2;
            4'd7, 4'd8, 4'd9:                          r = 3'd3;
            4'd10, 4'd11:                              r = 3'd4;
            4'd12, 4'd13, 4'd14:                       r = 3'd5;
            default:                                   r = 3'd6;
        endcase
        return r;
    endfunction

    // Bayer entry * 100 / 16, indexed by y[2:1], x[2:1]
    function automatic logic [INT_W-1:0] bayer_thr(input logic [1:0] y, input logic [1:0] x);
        logic [3:0] e;
        logic [INT_W-1:0] t;
        unique case ({y, x})
            4'h0: e = 4'd0;  4'h1: e = 4'd8;  4'h2: e = 4'd2;  4'h3: e = 4'd10;
            4'h4: e = 4'd12; 4'h5: e = 4'd4;  4'h6: e = 4'd14; 4'h7: e = 4'd6;
            4'h8: e = 4'd3;  4'h9: e = 4'd11; 4'hA: e = 4'd1;  4'hB: e = 4'd9;
            4'hC: e = 4'd15; 4'hD: e = 4'd7;  4'hE: e = 4'd13; default: e = 4'd5;
        endcase
        unique case (e)
            4'd0:  t = 7'd0;  4'd1:  t = 7'd6;  4'd2:  t = 7'd12; 4'd3:  t = 7'd18;
            4'd4:  t = 7'd25; 4'd5:  t = 7'd31; 4'd6:  t = 7'd37; 4'd7:  t = 7'd43;
            4'd8:  t = 7'd50; 4'd9:  t = 7'd56; 4'd10: t = 7'd62; 4'd11: t = 7'd68;
            4'd12: t = 7'd75; 4'd13: t = 7'd81; 4'd14: t = 7'd87; default: t = 7'd93;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dot_matrix_glyph_dither_emitter_unit.sv -----
// Top level of the 5x7 dot-matrix glyph emitter with dithered ghost grid.
// A transferred character passes through the descriptor queue, then the back-end dot walker and its output register.
// Each character gives 35 dots, one dot per cycle from the back-end dot walker while its output is empty or popped.
// Reset (synchronous, active low): queues empty, cursor 0, grid intensity 45.
// Instantiates dmge_front, dmge_queue and dmge_back; depends on dmge_pkg.
`default_nettype none

module dot_matrix_glyph_dither_emitter_unit #(
    parameter int QUEUE_DEPTH = dmge_pkg::QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [dmge_pkg::CODE_W-1:0]        i_char_code,
    input  wire logic                               i_new_string,
    input  wire logic signed [dmge_pkg::XY_W-1:0]   i_start_x,
    input  wire logic signed [dmge_pkg::XY_W-1:0]   i_row_y,
    input  wire logic [dmge_pkg::PITCH_W-1:0]       i_pitch,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [dmge_pkg::XY_W-1:0]        o_dot_x,
    output logic signed [dmge_pkg::XY_W-1:0]        o_dot_y,
    output logic [dmge_pkg::RAD_W-1:0]              o_radius,
    output logic                                    o_lit,
    output logic                                    o_draw,
    output logic                                    o_last,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [dmge_pkg::INT_W-1:0]         i_cfg_data
);

    logic [dmge_pkg::INT_W-1:0] r_grid_intensity;
    dmge_pkg::t_glyph_desc      front_desc, q_desc;
    dmge_pkg::t_back_status     back_status;
    logic                       in_xfer, q_valid, q_rd;
    logic [dmge_pkg::XY_W-1:0]  dot_x, dot_y;

    assign o_cfg_ready = 1'b1;
    assign in_xfer     = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_intensity <= dmge_pkg::GRID_INTENSITY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_grid_intensity <= i_cfg_data;
        end
    end

    dmge_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_xfer),
        .i_char_code  (i_char_code),
        .i_new_string (i_new_string),
        .i_start_x    (i_start_x),
        .i_row_y      (i_row_y),
        .i_pitch      (i_pitch),
        .o_desc       (front_desc)
    );

    dmge_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (front_desc),
        .o_full    (full),
        .i_rd      (q_rd),
        .o_valid   (q_valid),
        .o_rd_data (q_desc)
    );

    dmge_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_desc         (q_desc),
        .o_q_rd           (q_rd),
        .i_grid_intensity (r_grid_intensity),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_dot_x          (dot_x),
        .o_dot_y          (dot_y),
        .o_radius         (o_radius),
        .o_lit            (o_lit),
        .o_draw           (o_draw),
        .o_last           (o_last),
        .o_status         (back_status)
    );

    assign o_dot_x = dot_x;
    assign o_dot_y = dot_y;

    a_lit_drawn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_lit) |-> o_draw)
        else $error("lit dot not marked for drawing");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.busy |-> (back_status.row < dmge_pkg::ROW_W'(dmge_pkg::GLYPH_ROWS)
                              && back_status.col < dmge_pkg::COL_W'(dmge_pkg::GLYPH_COLS)))
        else $error("dot walker index out of range");

    a_no_idle_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!back_status.busy && q_valid) |=> back_status.busy)
        else $error("queued glyph not picked up by back end");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last && q_valid && $past(q_valid)) |-> back_status.busy)
        else $error("back end idle with glyph waiting after last dot");

endmodule

`default_nettype wire

// ----- rtl/core/dmge_front.sv -----
// Front end: font lookup, radius selection and cursor tracking per character.
// Depends on dmge_pkg.
`default_nettype none

module dmge_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [dmge_pkg::CODE_W-1:0]   i_char_code,
    input  wire logic                          i_new_string,
    input  wire logic [dmge_pkg::XY_W-1:0]     i_start_x,
    input  wire logic [dmge_pkg::XY_W-1:0]     i_row_y,
    input  wire logic [dmge_pkg::PITCH_W-1:0]  i_pitch,
    output dmge_pkg::t_glyph_desc              o_desc
);

    logic [dmge_pkg::XY_W-1:0] r_cursor_x;
    logic [dmge_pkg::XY_W-1:0] n_cursor_x;
    logic [dmge_pkg::XY_W-1:0] base_x;
    logic [dmge_pkg::XY_W-1:0] half_x;
    logic [dmge_pkg::XY_W-1:0] adv_x;

    assign base_x = i_new_string ? i_start_x : r_cursor_x;
    assign half_x = dmge_pkg::XY_W'(i_pitch >> 1);
    assign adv_x  = dmge_pkg::XY_W'(i_pitch) * dmge_pkg::XY_W'(dmge_pkg::ADVANCE_CELLS);
    assign n_cursor_x = base_x + adv_x;

    always_comb begin
        o_desc.bits    = dmge_pkg::font_bits(dmge_pkg::font_index(i_char_code));
        o_desc.x0      = base_x + half_x;
        o_desc.y0      = i_row_y + half_x;
        o_desc.pitch   = i_pitch;
        o_desc.ghost_r = dmge_pkg::ghost_radius(i_pitch);
        o_desc.lit_r   = dmge_pkg::lit_radius(i_pitch);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
        end else if (i_accept) begin
            r_cursor_x <= n_cursor_x;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dmge_queue.sv -----
// Short descriptor queue between front and back ends.
// Depends on dmge_pkg for the descriptor type.
`default_nettype none

module dmge_queue #(
    parameter int DEPTH = dmge_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire dmge_pkg::t_glyph_desc i_wr_data,
    output logic               o_full,
    input  wire logic          i_rd,
    output logic               o_valid,
    output dmge_pkg::t_glyph_desc o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dmge_pkg::t_glyph_desc r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full    = r_count == CNT_W'(DEPTH);
    assign o_valid   = r_count != '0;
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && o_valid;
    assign o_rd_data = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (rd_en) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dmge_back.sv -----
// Back end: walks the 35 dots of a glyph, one per cycle while the output is empty or popped, into the output register.
// Depends on dmge_pkg.
`default_nettype none

module dmge_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire dmge_pkg::t_glyph_desc        i_q_desc,
    output logic                              o_q_rd,
    input  wire logic [dmge_pkg::INT_W-1:0]   i_grid_intensity,
    input  wire logic                         i_pop,
    output logic                              o_empty,
    output logic [dmge_pkg::XY_W-1:0]         o_dot_x,
    output logic [dmge_pkg::XY_W-1:0]         o_dot_y,
    output logic [dmge_pkg::RAD_W-1:0]        o_radius,
    output logic                              o_lit,
    output logic                              o_draw,
    output logic                              o_last,
    output dmge_pkg::t_back_status            o_status
);

    logic                             r_busy;
    logic                             r_ovld;
    logic [dmge_pkg::ROW_W-1:0]       r_row;
    logic [dmge_pkg::COL_W-1:0]       r_col;
    dmge_pkg::t_glyph_bits            r_bits;
    logic [dmge_pkg::XY_W-1:0]        r_x0, r_dx, r_dy;
    logic [dmge_pkg::PITCH_W-1:0]     r_pitch;
    logic [dmge_pkg::RAD_W-1:0]       r_ghost_r, r_lit_r;

    logic [dmge_pkg::XY_W-1:0]        r_out_x, r_out_y;
    logic [dmge_pkg::RAD_W-1:0]       r_out_rad;
    logic                             r_out_lit, r_out_draw, r_out_last;

    logic adv, row_end, glyph_end, load, dot_on, dot_draw;
    logic [dmge_pkg::XY_W-1:0] step;

    assign adv       = r_busy && (!r_ovld || i_pop);
    assign row_end   = r_col == dmge_pkg::COL_W'(dmge_pkg::GLYPH_COLS - 1);
    assign glyph_end = row_end && (r_row == dmge_pkg::ROW_W'(dmge_pkg::GLYPH_ROWS - 1));
    assign load      = i_q_valid && (!r_busy || (adv && glyph_end));
    assign o_q_rd    = load;
    assign step      = dmge_pkg::XY_W'(r_pitch);

    assign dot_on   = r_bits[dmge_pkg::GLYPH_DOTS-1];
    assign dot_draw = dot_on || (i_grid_intensity > dmge_pkg::bayer_thr(r_dy[2:1], r_dx[2:1]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (adv && glyph_end) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_ovld <= 1'b1;
            end else if (i_pop) begin
                r_ovld <= 1'b0;
            end
            if (load) begin
                r_row <= '0;
                r_col <= '0;
            end else if (adv) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + dmge_pkg::ROW_W'(1);
                end else begin
                    r_col <= r_col + dmge_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bits    <= i_q_desc.bits;
            r_x0      <= i_q_desc.x0;
            r_dx      <= i_q_desc.x0;
            r_dy      <= i_q_desc.y0;
            r_pitch   <= i_q_desc.pitch;
            r_ghost_r <= i_q_desc.ghost_r;
            r_lit_r   <= i_q_desc.lit_r;
        end else if (adv) begin
            r_bits <= r_bits << 1;
            if (row_end) begin
                r_dx <= r_x0;
                r_dy <= r_dy + step;
            end else begin
                r_dx <= r_dx + step;
            end
        end
        if (adv) begin
            r_out_x    <= r_dx;
            r_out_y    <= r_dy;
            r_out_rad  <= dot_on ? r_lit_r : r_ghost_r;
            r_out_lit  <= dot_on;
            r_out_draw <= dot_draw;
            r_out_last <= glyph_end;
        end
    end

    assign o_empty  = !r_ovld;
    assign o_dot_x  = r_out_x;
    assign o_dot_y  = r_out_y;
    assign o_radius = r_out_rad;
    assign o_lit    = r_out_lit;
    assign o_draw   = r_out_draw;
    assign o_last   = r_out_last;

    always_comb begin
        o_status.busy = r_busy;
        o_status.row  = r_row;
        o_status.col  = r_col;
    end

endmodule

`default_nettype wire

// ----- verif/dot_matrix_glyph_dither_emitter_unit_tb.sv -----
// Self-checking testbench for dot_matrix_glyph_dither_emitter_unit (5x7 glyph dot emitter).
// A clocked driver transfers characters and grid intensity writes; a clocked monitor pops dots
// and checks them against an in-bench glyph renderer. Depends on dmge_pkg and the DUT only.
`timescale 1ns / 100ps

module dot_matrix_glyph_dither_emitter_unit_tb;

    localparam int CODE_W  = dmge_pkg::CODE_W;
    localparam int XY_W    = dmge_pkg::XY_W;
    localparam int PITCH_W = dmge_pkg::PITCH_W;
    localparam int RAD_W   = dmge_pkg::RAD_W;
    localparam int INT_W   = dmge_pkg::INT_W;
    localparam int DOTS    = dmge_pkg::GLYPH_DOTS;

    localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [63:0] DITHER_RANK = {
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    typedef enum logic [1:0] {OP_GLYPH, OP_CFG, OP_DRAIN} t_char_op;

    typedef struct {
        t_char_op                  op;
        logic [CODE_W-1:0]         code;
        logic                      nstr;
        logic signed [XY_W-1:0]    sx;
        logic signed [XY_W-1:0]    ry;
        logic [PITCH_W-1:0]        pitch;
        logic [INT_W-1:0]          level;
    } t_char_cmd;

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic [RAD_W-1:0]          r;
        logic                      lit;
        logic                      draw;
        logic                      last;
    } t_dot;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    logic [CODE_W-1:0]             i_char_code = '0;
    logic                          i_new_string = 1'b0;
    logic signed [XY_W-1:0]        i_start_x = '0;
    logic signed [XY_W-1:0]        i_row_y = '0;
    logic [PITCH_W-1:0]            i_pitch = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic signed [XY_W-1:0]        o_dot_x;
    logic signed [XY_W-1:0]        o_dot_y;
    logic [RAD_W-1:0]              o_radius;
    logic                          o_lit;
    logic                          o_draw;
    logic                          o_last;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [INT_W-1:0]              i_cfg_data = '0;

    t_char_cmd                     char_q[$];
    t_dot                          dot_q[$];
    t_char_cmd                     cur;
    bit                            have_cur = 1'b0;
    int                            gap_left = 0;
    int                            idle_cnt = 0;
    int                            stall_left = 0;
    int                            errors = 0;
    logic                          push_nxt;
    logic                          cfg_nxt;
    logic [XY_W-1:0]               cursor_x = '0;
    logic [INT_W-1:0]              grid_level = dmge_pkg::GRID_INTENSITY_RST;
    t_dot                          got;
    t_dot                          want;

    dot_matrix_glyph_dither_emitter_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_char_code  (i_char_code),
        .i_new_string (i_new_string),
        .i_start_x    (i_start_x),
        .i_row_y      (i_row_y),
        .i_pitch      (i_pitch),
        .empty        (empty),
        .pop          (pop),
        .o_dot_x      (o_dot_x),
        .o_dot_y      (o_dot_y),
        .o_radius     (o_radius),
        .o_lit        (o_lit),
        .o_draw       (o_draw),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Row 0 in the top five bits, left column first.
    function automatic logic [DOTS-1:0] glyph_pattern(input logic [CODE_W-1:0] code);
        logic [DOTS-1:0] p;
        case (code)
            dmge_pkg::CH_0:        p = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            dmge_pkg::CH_0 + 8'd1: p = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            dmge_pkg::CH_0 + 8'd2: p = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
            dmge_pkg::CH_0 + 8'd3: p = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            dmge_pkg::CH_0 + 8'd4: p = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            dmge_pkg::CH_0 + 8'd5: p = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
            dmge_pkg::CH_0 + 8'd6: p = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            dmge_pkg::CH_0 + 8'd7: p = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            dmge_pkg::CH_0 + 8'd8: p = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            dmge_pkg::CH_9:        p = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            dmge_pkg::CH_COLON:    p = {5'h00, 5'h00, 5'h04, 5'h00, 5'h04, 5'h00, 5'h00};
            dmge_pkg::CH_SLASH:    p = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
            dmge_pkg::CH_DASH:     p = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            dmge_pkg::CH_DOT:      p = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
            dmge_pkg::CH_PERCENT:  p = {5'h19, 5'h1A, 5'h04, 5'h0B, 5'h13, 5'h00, 5'h00};
            default:               p = '0;
        endcase
        return p;
    endfunction

    function automatic void render_glyph(input t_char_cmd c);
        logic [DOTS-1:0] pat;
        logic [31:0]     tx;
        logic [31:0]     ty;
        int              p;
        int              gr;
        int              lr;
        int              thr;
        int              n;
        t_dot            d;
        p = int'(c.pitch);
        gr = p * 30 / 100;
        if (gr < 1) gr = 1;
        lr = p * 42 / 100;
        if (lr < gr + 1) lr = gr + 1;
        if (c.nstr) cursor_x = c.sx;
        pat = glyph_pattern(c.code);
        for (int row = 0; row < dmge_pkg::GLYPH_ROWS; row++) begin
            ty = int'(c.ry[XY_W-1:0]) + row * p + p / 2;
            for (int col = 0; col < dmge_pkg::GLYPH_COLS; col++) begin
                n = row * dmge_pkg::GLYPH_COLS + col;
                tx = int'(cursor_x) + col * p + p / 2;
                d.x = tx[XY_W-1:0];
                d.y = ty[XY_W-1:0];
                d.lit = pat[DOTS-1-n];
                thr = int'(DITHER_RANK[63 - 4 * (int'(ty[2:1]) * 4 + int'(tx[2:1])) -: 4])
                      * 100 / 16;
                d.draw = d.lit | (int'(grid_level) > thr);
                d.r = d.lit ? lr[RAD_W-1:0] : gr[RAD_W-1:0];
                d.last = (n == DOTS - 1);
                dot_q.push_back(d);
            end
        end
        cursor_x = cursor_x + XY_W'(dmge_pkg::ADVANCE_CELLS * p);
    endfunction

    function automatic void add_glyph(input logic [CODE_W-1:0] code, input logic nstr,
                                      input logic [XY_W-1:0] sx, input logic [XY_W-1:0] ry,
                                      input logic [PITCH_W-1:0] pitch);
        t_char_cmd c;
        c.op = OP_GLYPH;
        c.code = code;
        c.nstr = nstr;
        c.sx = sx;
        c.ry = ry;
        c.pitch = pitch;
        c.level = '0;
        char_q.push_back(c);
    endfunction

    function automatic void add_cmd(input t_char_op op, input logic [INT_W-1:0] level);
        t_char_cmd c;
        c.op = op;
        c.code = '0;
        c.nstr = 1'b0;
        c.sx = '0;
        c.ry = '0;
        c.pitch = '0;
        c.level = level;
        char_q.push_back(c);
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] k;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: k = dmge_pkg::CH_0 + CODE_W'($urandom_range(0, 9));
            10:      k = dmge_pkg::CH_COLON;
            11:      k = dmge_pkg::CH_SLASH;
            12:      k = dmge_pkg::CH_DASH;
            13:      k = dmge_pkg::CH_DOT;
            14:      k = dmge_pkg::CH_PERCENT;
            15:      k = CH_SPACE;
            default: k = CODE_W'($urandom_range(0, 255));
        endcase
        return k;
    endfunction

    // Driver: one pending character or register write at a time.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            i_cfg_valid <= 1'b0;
            have_cur = 1'b0;
            gap_left = 0;
            idle_cnt = 0;
            cursor_x = '0;
            grid_level = dmge_pkg::GRID_INTENSITY_RST;
        end else begin
            if (push && !full) begin
                render_glyph(cur);
                have_cur = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                grid_level = cur.level;
                have_cur = 1'b0;
            end
            idle_cnt = (dot_q.size() == 0) ? idle_cnt + 1 : 0;
            if (!have_cur && char_q.size() != 0) begin
                cur = char_q.pop_front();
                have_cur = 1'b1;
                gap_left = (char_q.size() > 25 && $urandom_range(0, 4) == 0) ?
                           int'($urandom_range(1, 19)) : 0;
            end
            push_nxt = 1'b0;
            cfg_nxt = 1'b0;
            if (have_cur) begin
                case (cur.op)
                    OP_GLYPH: begin
                        if (gap_left > 0) gap_left--;
                        else push_nxt = 1'b1;
                    end
                    OP_CFG: begin
                        if (i_cfg_valid || idle_cnt >= 4) cfg_nxt = 1'b1;
                    end
                    default: begin
                        if (dot_q.size() == 0) have_cur = 1'b0;
                    end
                endcase
            end
            push <= push_nxt;
            i_cfg_valid <= cfg_nxt;
            i_char_code <= cur.code;
            i_new_string <= cur.nstr;
            i_start_x <= cur.sx;
            i_row_y <= cur.ry;
            i_pitch <= cur.pitch;
            i_cfg_data <= cur.level;
        end
    end

    // Monitor: pops dots with random stall bursts and checks each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_left = 0;
        end else begin
            if (pop && !empty) begin
                got.x = o_dot_x;
                got.y = o_dot_y;
                got.r = o_radius;
                got.lit = o_lit;
                got.draw = o_draw;
                got.last = o_last;
                if (dot_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected dot x=%0d y=%0d r=%0d lit=%0b draw=%0b",
                                 $realtime, got.x, got.y, got.r, got.lit, got.draw,
                                 " last=%0b", got.last);
                end else begin
                    want = dot_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: dot mismatch exp x=%0d y=%0d r=%0d lit=%0b",
                                     $realtime, want.x, want.y, want.r, want.lit,
                                     " draw=%0b last=%0b", want.draw, want.last,
                                     " got x=%0d y=%0d r=%0d lit=%0b", got.x, got.y,
                                     got.r, got.lit,
                                     " draw=%0b last=%0b", got.draw, got.last);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (char_q.size() > 25 && $urandom_range(0, 24) == 0) begin
                stall_left = int'($urandom_range(1, 19)) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        logic [INT_W-1:0] lvl;
        // directed: extremes, every glyph, unknown codes, zero pitch, coordinate wrap
        add_glyph(dmge_pkg::CH_0, 1'b1, -11'sd1024, -11'sd1024, 4'd15);
        add_glyph(dmge_pkg::CH_0 + 8'd1, 1'b0, 11'sd0, -11'sd1024, 4'd15);
        add_glyph(dmge_pkg::CH_0 + 8'd2, 1'b0, 11'sd5, 11'sd0, 4'd1);
        add_glyph(dmge_pkg::CH_0 + 8'd3, 1'b0, 11'sd0, 11'sd100, 4'd0);
        add_glyph(dmge_pkg::CH_0 + 8'd4, 1'b1, 11'sd300, -11'sd50, 4'd2);
        add_glyph(dmge_pkg::CH_0 + 8'd5, 1'b0, 11'sd0, -11'sd50, 4'd3);
        add_glyph(dmge_pkg::CH_0 + 8'd6, 1'b0, 11'sd0, -11'sd50, 4'd7);
        add_glyph(dmge_pkg::CH_0 + 8'd7, 1'b0, 11'sd0, 11'sd200, 4'd10);
        add_glyph(dmge_pkg::CH_0 + 8'd8, 1'b0, 11'sd0, 11'sd200, 4'd12);
        add_glyph(dmge_pkg::CH_9, 1'b0, 11'sd0, 11'sd200, 4'd14);
        add_glyph(dmge_pkg::CH_COLON, 1'b1, -11'sd700, 11'sd33, 4'd5);
        add_glyph(dmge_pkg::CH_SLASH, 1'b0, 11'sd0, 11'sd33, 4'd6);
        add_glyph(dmge_pkg::CH_DASH, 1'b0, 11'sd0, 11'sd33, 4'd8);
        add_glyph(dmge_pkg::CH_DOT, 1'b0, 11'sd0, 11'sd33, 4'd9);
        add_glyph(dmge_pkg::CH_PERCENT, 1'b0, 11'sd0, 11'sd33, 4'd11);
        add_glyph(CH_SPACE, 1'b0, 11'sd0, 11'sd33, 4'd13);
        add_glyph(8'h00, 1'b0, 11'sd0, 11'sd33, 4'd4);
        add_glyph(8'hFF, 1'b0, 11'sd0, 11'sd33, 4'd15);
        add_glyph(8'h41, 1'b0, 11'sd0, 11'sd33, 4'd1);
        add_glyph(dmge_pkg::CH_0 + 8'd8, 1'b1, 11'sd1023, 11'sd1023, 4'd15);
        add_cmd(OP_CFG, 7'd0);
        add_glyph(dmge_pkg::CH_DASH, 1'b1, 11'sd17, 11'sd9, 4'd7);
        add_glyph(CH_SPACE, 1'b0, 11'sd0, 11'sd9, 4'd7);
        add_cmd(OP_CFG, 7'd127);
        add_glyph(8'h7F, 1'b0, 11'sd0, 11'sd9, 4'd4);
        add_glyph(dmge_pkg::CH_0 + 8'd8, 1'b0, 11'sd0, 11'sd9, 4'd0);
        add_cmd(OP_CFG, 7'd100);
        add_glyph(CH_SPACE, 1'b0, 11'sd0, -11'sd9, 4'd12);
        // random phases, each at its own grid intensity
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       lvl = 7'd1;
                1:       lvl = 7'd99;
                7:       lvl = dmge_pkg::GRID_INTENSITY_RST;
                default: lvl = INT_W'($urandom_range(0, 127));
            endcase
            add_cmd(OP_CFG, lvl);
            for (int k = 0; k < 24; k++) begin
                if (ph == 3 && k == 14) add_cmd(OP_DRAIN, '0);
                add_glyph(pick_code(), (k == 0 || $urandom_range(0, 5) == 0),
                          XY_W'($urandom_range(0, 2047)), XY_W'($urandom_range(0, 2047)),
                          PITCH_W'($urandom_range(0, 15)));
            end
        end

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (char_q.size() != 0 || have_cur || dot_q.size() != 0);
        repeat (8) @(posedge i_clk);
        if (errors == 0) $display("dot_matrix_glyph_dither_emitter_unit_tb: PASS");
        else $display("dot_matrix_glyph_dither_emitter_unit_tb: FAIL");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("dot_matrix_glyph_dither_emitter_unit_tb: FAIL");
        $finish;
    end

endmodule
